/* design/septet_packer_unpacker_core_defines.svh */
// Assertion macros for the septet packer and unpacker core
`ifndef SEPTET_PACKER_UNPACKER_CORE_DEFINES_SVH
`define SEPTET_PACKER_UNPACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPU_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPU_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/spu_pkg.sv */
// Shared types and constants of the septet packer and unpacker
`timescale 1ns / 1ps
package spu_pkg;

	localparam int unsigned MAX_UNITS = 255;

	typedef enum logic [2:0] {
		REG_DIRECTION   = 3'd0,
		REG_ALPHABET    = 3'd1,
		REG_BINARY_DATA = 3'd2,
		REG_START_BIT   = 3'd3,
		REG_UNIT_COUNT  = 3'd4,
		REG_OUT_ROOM    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_OVERFLOW    = 2'd1,
		ST_SHORT       = 2'd2,
		ST_UNSUPPORTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALPHA_7BIT  = 2'd0,
		ALPHA_8BIT  = 2'd1,
		ALPHA_UCS2  = 2'd2,
		ALPHA_UNSUP = 2'd3
	} alphabet_t;

	typedef enum logic [1:0] {
		ELEM_NONE = 2'd0,
		ELEM_7    = 2'd1,
		ELEM_8    = 2'd2
	} elem_t;

	typedef struct packed {
		logic       direction;
		logic [1:0] alphabet;
		logic       binary_data;
		logic [2:0] start_bit;
		logic [7:0] unit_count;
		logic [7:0] out_room;
	} cfg_t;

	// up to two results caused by one input transaction
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] d0;
		logic [7:0] d1;
		status_t    status;
		logic       last;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

/* design/spu_stream_if.sv */
// Valid/ready stream interfaces for input items and result items
`timescale 1ns / 1ps
interface spu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       last_in;

	modport source (output valid, output data_in, output last_in, input ready);
	modport sink (input valid, input data_in, input last_in, output ready);
endinterface

interface spu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic [1:0] status;
	logic       last_out;

	modport source (output valid, output data_out, output status, output last_out, input ready);
	modport sink (input valid, input data_out, input status, input last_out, output ready);
endinterface

/* design/spu_front.sv */
// Front end: accepts items, runs message checks and the bit buffer, builds result jobs
`timescale 1ns / 1ps
module spu_front
	import spu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	spu_in_if.sink     rx,
	input  q_stat_t    q_stat,
	output logic       push,
	output job_t       job
);

	logic [14:0] buf_q, nb;
	logic [3:0]  held_q, nh;
	logic [7:0]  done_q, nd;
	logic [8:0]  os_q, nos;
	logic        err_q, nerr;

	logic        accept;
	logic        first;
	elem_t       elem;
	logic [7:0]  uc;
	logic [10:0] bit_sum;
	logic [8:0]  oct_need;
	status_t     st_chk;
	logic        stop;
	logic        rst_msg;
	logic        shrt;
	logic [7:0]  tail_mask;

	assign rx.ready = !q_stat.full;
	assign accept   = rx.valid && rx.ready;
	assign first    = (os_q == 9'd0);

	always_comb begin
		if (cfg.binary_data) begin
			elem = ELEM_8;
		end else begin
			case (cfg.alphabet)
				ALPHA_7BIT: elem = ELEM_7;
				ALPHA_8BIT: elem = ELEM_8;
				ALPHA_UCS2: elem = ELEM_8;
				default:    elem = ELEM_NONE;
			endcase
		end
	end

	assign uc = ({8'd0, cfg.unit_count} < 16'(MAX_UNITS)) ? cfg.unit_count : 8'(MAX_UNITS);
	assign bit_sum = 11'(cfg.start_bit) + 11'(uc) * 11'd7 + 11'd7;
	assign oct_need = (elem == ELEM_8) ? {1'b0, uc} : 9'(bit_sum >> 3);

	always_comb begin
		if (elem == ELEM_NONE) begin
			st_chk = ST_UNSUPPORTED;
		end else if (!cfg.direction && (oct_need > {1'b0, cfg.out_room})) begin
			st_chk = ST_OVERFLOW;
		end else if (cfg.direction && (uc > cfg.out_room)) begin
			st_chk = ST_SHORT;
		end else begin
			st_chk = ST_OK;
		end
	end

	always_comb begin
		nb        = buf_q;
		nh        = held_q;
		nd        = done_q;
		nos       = os_q;
		nerr      = err_q;
		job       = '0;
		job.status = ST_OK;
		stop      = 1'b0;
		rst_msg   = 1'b0;
		shrt      = 1'b0;
		tail_mask = 8'd0;

		if (err_q) begin
			rst_msg = rx.last_in;
		end else begin
			if (first) begin
				nb = 15'd0;
				nh = cfg.direction ? 4'd0 : {1'b0, cfg.start_bit};
				nd = 8'd0;
				if (st_chk != ST_OK) begin
					job.cnt    = 2'd1;
					job.status = st_chk;
					job.last   = 1'b1;
					stop       = 1'b1;
					if (rx.last_in) begin
						rst_msg = 1'b1;
					end else begin
						nerr = 1'b1;
						nos  = 9'd1;
					end
				end
			end
			if (!stop) begin
				nos = (os_q != '1) ? os_q + 9'd1 : os_q;
				if (!cfg.direction) begin
					shrt = ({1'b0, nd} + 9'd1) < {1'b0, uc};
				end else begin
					shrt = nos < oct_need;
				end
				if (rx.last_in && (elem != ELEM_NONE) && shrt) begin
					job.cnt    = 2'd1;
					job.status = ST_SHORT;
					job.last   = 1'b1;
					rst_msg    = 1'b1;
					stop       = 1'b1;
				end
			end
			if (!stop) begin
				if (elem == ELEM_8) begin
					if (nd < uc) begin
						job.cnt = 2'd1;
						job.d0  = rx.data_in;
						nd      = nd + 8'd1;
					end
				end else if ((elem == ELEM_7) && !cfg.direction) begin
					if ((nd < uc) && (nh <= 4'd8)) begin
						nb = nb | ({8'd0, rx.data_in[6:0]} << nh);
						nh = nh + 4'd7;
						nd = nd + 8'd1;
						if (nh >= 4'd8) begin
							job.cnt = 2'd1;
							job.d0  = nb[7:0];
							nb      = nb >> 8;
							nh      = nh - 4'd8;
						end
					end
					if (rx.last_in && (nh != 4'd0) && (nh < 4'd8)) begin
						tail_mask = ~(8'hFF << nh[2:0]);
						if (job.cnt == 2'd0) begin
							job.d0 = nb[7:0] & tail_mask;
						end else begin
							job.d1 = nb[7:0] & tail_mask;
						end
						job.cnt = job.cnt + 2'd1;
					end
				end else if (elem == ELEM_7) begin
					if (nd < uc) begin
						if (first) begin
							nb = 15'(rx.data_in >> cfg.start_bit);
							nh = 4'd8 - {1'b0, cfg.start_bit};
						end else if (nh <= 4'd7) begin
							nb = nb | (15'(rx.data_in) << nh);
							nh = nh + 4'd8;
						end
						for (int k = 0; k < 2; k++) begin
							if ((nh >= 4'd7) && (nd < uc)) begin
								if (job.cnt == 2'd0) begin
									job.d0 = {1'b0, nb[6:0]};
								end else begin
									job.d1 = {1'b0, nb[6:0]};
								end
								job.cnt = job.cnt + 2'd1;
								nb      = nb >> 7;
								nh      = nh - 4'd7;
								nd      = nd + 8'd1;
							end
						end
					end
				end
				if (rx.last_in) begin
					if (job.cnt == 2'd0) begin
						job.cnt = 2'd1;
					end
					job.last = 1'b1;
					rst_msg  = 1'b1;
				end
			end
		end

		if (rst_msg) begin
			nb   = 15'd0;
			nh   = {1'b0, cfg.start_bit};
			nd   = 8'd0;
			nos  = 9'd0;
			nerr = 1'b0;
		end
	end

	assign push = accept && (job.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= 15'd0;
			held_q <= 4'd0;
			done_q <= 8'd0;
			os_q   <= 9'd0;
			err_q  <= 1'b0;
		end else if (accept) begin
			buf_q  <= nb;
			held_q <= nh;
			done_q <= nd;
			os_q   <= nos;
			err_q  <= nerr;
		end
	end

endmodule

/* design/spu_queue.sv */
// Job queue between front end and back end
`timescale 1ns / 1ps
module spu_queue
	import spu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    job_in,
	input  logic    pop,
	output job_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/spu_back.sv */
// Back end: takes jobs from the queue and issues their results one per cycle while tx.ready is high
`timescale 1ns / 1ps
module spu_back
	import spu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  job_t    head,
	output logic    pop,
	spu_out_if.source tx
);

	job_t job_q;
	logic idx_q;
	logic valid_q;
	logic fin;

	assign fin         = (idx_q == (job_q.cnt == 2'd2));
	assign pop         = !q_stat.empty && (!valid_q || (tx.ready && fin));
	assign tx.valid    = valid_q;
	assign tx.data_out = idx_q ? job_q.d1 : job_q.d0;
	assign tx.status   = job_q.status;
	assign tx.last_out = job_q.last && fin;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (valid_q && tx.ready) begin
			if (fin) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

endmodule

/* design/septet_packer_unpacker_core.sv */
// Top level of the GSM 7-bit septet packer and unpacker
// Path: an accepted input transaction is stored as a job in the queue, then moved into the output register.
// Throughput: one input transaction per cycle while the queue is not full; one result per cycle
// leaves while tx.ready is high, a two-result item issues both in turn, QUEUE_DEPTH jobs buffer the difference.
// Reset: arst_n clears message state, queue and output; registers return to their defaults.
`timescale 1ns / 1ps
`include "septet_packer_unpacker_core_defines.svh"
module septet_packer_unpacker_core
	import spu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	spu_in_if.sink     rx,
	spu_out_if.source  tx,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	job_t    job_new;
	job_t    q_head;
	logic    push;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= 1'b0;
			cfg_q.alphabet    <= ALPHA_7BIT;
			cfg_q.binary_data <= 1'b0;
			cfg_q.start_bit   <= 3'd0;
			cfg_q.unit_count  <= 8'd0;
			cfg_q.out_room    <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIRECTION:   cfg_q.direction   <= cfg_wdata[0];
				REG_ALPHABET:    cfg_q.alphabet    <= cfg_wdata[1:0];
				REG_BINARY_DATA: cfg_q.binary_data <= cfg_wdata[0];
				REG_START_BIT:   cfg_q.start_bit   <= cfg_wdata[2:0];
				REG_UNIT_COUNT:  cfg_q.unit_count  <= cfg_wdata;
				REG_OUT_ROOM:    cfg_q.out_room    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	spu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.rx     (rx),
		.q_stat (q_stat),
		.push   (push),
		.job    (job_new)
	);

	spu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job_in (job_new),
		.pop    (pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	spu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (q_head),
		.pop    (pop),
		.tx     (tx)
	);

	`SPU_ASSERT_NOW(a_err_result, clk, arst_n, tx.valid && (tx.status != ST_OK), (tx.data_out == 8'd0) && tx.last_out, "error result must carry zero data and end the message")
	`SPU_ASSERT_NEXT(a_queue_drain, clk, arst_n, !q_stat.empty && !tx.valid, tx.valid, "queued job not moved to the output")

endmodule
